// ===== sv/arccosine_poly_approx_core_assert.svh =====
// ----------------------------------------------------------------------------
// Arc cosine core assertion macros
// Concurrent assertion wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef ARCCOSINE_POLY_APPROX_CORE_ASSERT_SVH
`define ARCCOSINE_POLY_APPROX_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ACPA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ACPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ACPA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ACPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/acpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Arc cosine core package
// Constants, coefficient set, root cell payload and Q.32 multiply helper.
// ----------------------------------------------------------------------------
package acpa_pkg;

   localparam int FRAC_BITS_DEF = 14;
   localparam int ROOT_CELLS    = 31;

   localparam logic [32:0] PIH_Q32 = 33'd6746518852;
   localparam logic [31:0] C0 = 32'd332542219;
   localparam logic [31:0] C1 = 32'd112236703;
   localparam logic [31:0] C2 = 32'd331258064;
   localparam logic [31:0] C3 = 32'd715667221;

   typedef struct packed {
      logic [61:0] rad;
      logic [31:0] rem;
      logic [30:0] root;
      logic [31:0] m_small;
      logic        big;
      logic        neg;
      logic        flag;
   } sqrt_cell_type;

   // product rounded to nearest, ties up, back to Q.32
   function automatic logic [31:0] mul_q32(input logic [31:0] a, input logic [31:0] b);
      logic [64:0] pr;
      pr = ({33'd0, a} * {33'd0, b}) + {33'd0, 32'h8000_0000};
      return pr[63:32];
   endfunction

endpackage

// ===== sv/acpa_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Arc cosine square root cell
// One digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
module acpa_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic                    in_valid,
   input  acpa_pkg::sqrt_cell_type in_data,
   output logic                    out_valid,
   output acpa_pkg::sqrt_cell_type out_data
);

   logic [33:0]             cur;
   logic [33:0]             trial;
   acpa_pkg::sqrt_cell_type data_in;
   acpa_pkg::sqrt_cell_type data_ff;
   logic                    valid_ff;

   always_comb begin
      cur          = {in_data.rem, in_data.rad[61:60]};
      trial        = {1'b0, in_data.root, 2'b01};
      data_in      = in_data;
      data_in.rad  = {in_data.rad[59:0], 2'b00};
      if (cur >= trial) begin
         data_in.rem  = 32'(cur - trial);
         data_in.root = {in_data.root[29:0], 1'b1};
      end else begin
         data_in.rem  = cur[31:0];
         data_in.root = {in_data.root[29:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/arccosine_poly_approx_core.sv =====
// ----------------------------------------------------------------------------
// Arc cosine core
// acos of a signed Q2.F argument as an unsigned Q2.F angle, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | ports                         | transfer
//  req     | in        | req_x_value                   | req_valid & !req_stall
//  rsp     | out       | rsp_angle, rsp_out_of_range   | rsp_valid & !rsp_stall
//
// One argument per cycle while req_stall is low. The pipeline holds the input
// register, 31 root cells (one result bit each) and 7 multiply and add stages.
// Reset clears the valid bits only. A result held in the skid register raises
// req_stall and freezes the pipeline until it is taken.
// ----------------------------------------------------------------------------
`include "arccosine_poly_approx_core_assert.svh"

module arccosine_poly_approx_core #(
   parameter int FRAC_BITS = acpa_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [FRAC_BITS+1:0] req_x_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FRAC_BITS+1:0]   rsp_angle,
   output logic                   rsp_out_of_range
);

   localparam int IO_W  = FRAC_BITS + 2;
   localparam int SH    = 32 - FRAC_BITS;
   localparam int CELLS = acpa_pkg::ROOT_CELLS;
   localparam logic [34:0] PI_RND =
      (({2'b00, acpa_pkg::PIH_Q32} << 1) + (35'd1 << (SH - 1))) >> SH;
   localparam logic [IO_W-1:0] PI_OUT = PI_RND[IO_W-1:0];

   typedef struct packed {
      logic big;
      logic neg;
      logic flag;
   } side_type;

   logic en;
   logic skid_vld_ff;

   // ---------------- input stage ----------------
   logic [IO_W:0]           mag;
   logic [FRAC_BITS:0]      mag_c;
   logic                    flag;
   logic [32:0]             a_q;
   logic [32:0]             t_q;
   acpa_pkg::sqrt_cell_type s0_in;
   acpa_pkg::sqrt_cell_type cell_d [0:CELLS];
   logic                    cell_v [0:CELLS];
   logic                    s0_vld_ff;
   acpa_pkg::sqrt_cell_type s0_ff;

   always_comb begin
      mag = req_x_value[IO_W-1] ? ({1'b0, ~req_x_value} + (IO_W+1)'(1))
                                : {1'b0, req_x_value};
      flag  = mag > ((IO_W+1)'(1) << FRAC_BITS);
      mag_c = flag ? ((FRAC_BITS+1)'(1) << FRAC_BITS) : mag[FRAC_BITS:0];
      a_q   = {mag_c, {SH{1'b0}}};
      t_q   = ((33'd1 << 32) - a_q) >> 1;
      s0_in.rad     = {t_q[29:0], 32'd0};
      s0_in.rem     = '0;
      s0_in.root    = '0;
      s0_in.m_small = a_q[31:0];
      s0_in.big     = a_q > 33'h0_8000_0000;
      s0_in.neg     = req_x_value[IO_W-1];
      s0_in.flag    = flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
      end
   end

   assign cell_d[0] = s0_ff;
   assign cell_v[0] = s0_vld_ff;

   // ---------------- root cell chain ----------------
   for (genvar k = 1; k <= CELLS; k++) begin : g_cell
      acpa_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .load      (en),
         .in_valid  (cell_v[k-1]),
         .in_data   (cell_d[k-1]),
         .out_valid (cell_v[k]),
         .out_data  (cell_d[k])
      );
   end

   // ---------------- polynomial stages ----------------
   logic [6:0]  pv_ff;
   side_type    sd_ff [0:6];
   logic [31:0] m_in;
   logic [31:0] m_ff  [0:3];
   logic [31:0] x2_ff [0:2];
   logic [31:0] m3_ff [1:3];
   logic [31:0] p_ff  [1:3];
   logic [32:0] s_ff;
   logic [33:0] sadj_in;
   logic [33:0] sadj_ff;
   logic [34:0] res_in;
   logic [34:0] rnd_in;
   logic [IO_W-1:0] angle_ff;

   assign m_in = cell_d[CELLS].big ? {1'b0, cell_d[CELLS].root} : cell_d[CELLS].m_small;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (en) begin
         pv_ff <= {pv_ff[5:0], cell_v[CELLS]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= '{big: cell_d[CELLS].big, neg: cell_d[CELLS].neg,
                       flag: cell_d[CELLS].flag};
         for (int j = 1; j < 7; j++) begin
            sd_ff[j] <= sd_ff[j-1];
         end
         // square of the reduced argument
         m_ff[0]  <= m_in;
         x2_ff[0] <= acpa_pkg::mul_q32(m_in, m_in);
         // first Horner step and cube in parallel
         m_ff[1]  <= m_ff[0];
         x2_ff[1] <= x2_ff[0];
         m3_ff[1] <= acpa_pkg::mul_q32(m_ff[0], x2_ff[0]);
         p_ff[1]  <= acpa_pkg::mul_q32(acpa_pkg::C0, x2_ff[0]) + acpa_pkg::C1;
         m_ff[2]  <= m_ff[1];
         x2_ff[2] <= x2_ff[1];
         m3_ff[2] <= m3_ff[1];
         p_ff[2]  <= acpa_pkg::mul_q32(p_ff[1], x2_ff[1]) + acpa_pkg::C2;
         m_ff[3]  <= m_ff[2];
         m3_ff[3] <= m3_ff[2];
         p_ff[3]  <= acpa_pkg::mul_q32(p_ff[2], x2_ff[2]) + acpa_pkg::C3;
         s_ff     <= {1'b0, m_ff[3]} + {1'b0, acpa_pkg::mul_q32(m3_ff[3], p_ff[3])};
         sadj_ff  <= sadj_in;
         angle_ff <= rnd_in[SH +: IO_W];
      end
   end

   always_comb begin
      if (sd_ff[4].big) begin
         sadj_in = ({s_ff, 1'b0} >= {1'b0, acpa_pkg::PIH_Q32}) ? '0
                 : {1'b0, acpa_pkg::PIH_Q32} - {s_ff, 1'b0};
      end else begin
         sadj_in = {1'b0, s_ff};
      end
   end

   always_comb begin
      if (sd_ff[5].neg) begin
         res_in = {2'b00, acpa_pkg::PIH_Q32} + {1'b0, sadj_ff};
         if (res_in > {1'b0, acpa_pkg::PIH_Q32, 1'b0}) begin
            res_in = {1'b0, acpa_pkg::PIH_Q32, 1'b0};
         end
      end else begin
         res_in = (sadj_ff >= {1'b0, acpa_pkg::PIH_Q32}) ? '0
                : {1'b0, {1'b0, acpa_pkg::PIH_Q32} - sadj_ff};
      end
      rnd_in = res_in + (35'd1 << (SH - 1));
   end

   // ---------------- output skid ----------------
   logic [IO_W-1:0] skid_angle_ff;
   logic            skid_flag_ff;
   logic            last_vld;

   assign last_vld = pv_ff[6];
   assign en       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         skid_vld_ff <= rsp_stall;
      end else begin
         skid_vld_ff <= last_vld && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_angle_ff <= angle_ff;
         skid_flag_ff  <= sd_ff[6].flag;
      end
   end

   assign rsp_valid        = skid_vld_ff || last_vld;
   assign rsp_angle        = skid_vld_ff ? skid_angle_ff : angle_ff;
   assign rsp_out_of_range = skid_vld_ff ? skid_flag_ff : sd_ff[6].flag;

   `ACPA_ASSERT_IMPL(a_clamp_edge, clock, reset, rsp_valid && rsp_out_of_range,
      rsp_angle == '0 || rsp_angle == PI_OUT, "clamped result is not 0 or pi")
   `ACPA_ASSERT_IMPL(a_angle_max, clock, reset, rsp_valid, rsp_angle <= PI_OUT,
      "angle above pi")
   `ACPA_ASSERT_NEXT(a_skid_hold, clock, reset, !skid_vld_ff && last_vld && rsp_stall,
      skid_vld_ff && rsp_angle == $past(angle_ff), "skid lost stalled result")

endmodule
